// File: rtl/core/usm_pkg.sv
// Package: shared types, codes and constants for the UV sphere mesh generator.
`default_nettype none
package usm_pkg;

    localparam logic [1:0] KIND_POS  = 2'd0;
    localparam logic [1:0] KIND_NORM = 2'd1;
    localparam logic [1:0] KIND_TRI  = 2'd2;
    localparam logic [1:0] KIND_REJ  = 2'd3;

    localparam logic [1:0] CFG_RADIUS   = 2'd0;
    localparam logic [1:0] CFG_BANDS    = 2'd1;
    localparam logic [1:0] CFG_SEGMENTS = 2'd2;

    localparam int ATAN_LEN = 24;
    localparam logic signed [32:0] GAIN_Q30 = 33'sd652032875;
    localparam logic signed [32:0] ONE_Q30  = 33'sd1073741824;

    // arctangent of 2^-k in turns, 2^32 per turn
    localparam logic [29:0] ATAN_TURNS [0:ATAN_LEN-1] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    typedef struct packed {
        logic [7:0] band_index;
        logic [7:0] segment_index;
    } t_in;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [19:0] vec_x;
        logic signed [19:0] vec_y;
        logic signed [19:0] vec_z;
        logic [16:0]        tex_s;
        logic [16:0]        tex_t;
        logic [15:0]        corner_a;
        logic [15:0]        corner_b;
        logic [15:0]        corner_c;
        logic               last_of_run;
    } t_out;

    // per grid point bookkeeping carried down the pipe
    typedef struct packed {
        logic        rej;
        logic        up;
        logic        lo;
        logic [15:0] k1;
        logic [15:0] k2;
    } t_meta;

    typedef struct packed {
        logic [7:0]  r;
        logic [32:0] q;
    } t_div_lane;

    typedef struct packed {
        t_div_lane lat;
        t_div_lane lon;
        logic      rb_s;
        logic      rb_t;
        logic      rb_lat;
        logic      rb_lon;
        t_meta     meta;
    } t_div;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [33:0] z;
        logic [1:0]         q;
    } t_rot;

    typedef struct packed {
        t_meta       meta;
        logic [16:0] tex_s;
        logic [16:0] tex_t;
    } t_side;

    typedef struct packed {
        t_rot  lat;
        t_rot  lon;
        t_side side;
    } t_cord;

endpackage
`default_nettype wire

// File: rtl/core/usm_div_cell.sv
// One restoring division step for the latitude and longitude lanes.
`default_nettype none
module usm_div_cell #(
    parameter int K = 1
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic         i_v,
    input  wire usm_pkg::t_div i_d,
    input  wire logic [7:0]   i_nb,
    input  wire logic [7:0]   i_ns,
    output logic              o_v,
    output usm_pkg::t_div     o_d
);

    logic [8:0]    lat_r2, lon_r2;
    logic          lat_bit, lon_bit;
    logic [7:0]    lat_rn, lon_rn;
    logic          lat_rnd, lon_rnd;
    usm_pkg::t_div n_d;
    usm_pkg::t_div r_d;
    logic          r_v;

    always_comb begin
        lat_r2  = {i_d.lat.r, 1'b0};
        lon_r2  = {i_d.lon.r, 1'b0};
        lat_bit = lat_r2 >= {1'b0, i_nb};
        lon_bit = lon_r2 >= {1'b0, i_ns};
        lat_rn  = lat_bit ? 8'(lat_r2 - {1'b0, i_nb}) : lat_r2[7:0];
        lon_rn  = lon_bit ? 8'(lon_r2 - {1'b0, i_ns}) : lon_r2[7:0];
        // round half up: remainder plus half the divisor reaches the divisor
        lat_rnd = ({1'b0, lat_rn} + {2'b0, i_nb[7:1]}) >= {1'b0, i_nb};
        lon_rnd = ({1'b0, lon_rn} + {2'b0, i_ns[7:1]}) >= {1'b0, i_ns};

        n_d       = i_d;
        n_d.lat.r = lat_rn;
        n_d.lon.r = lon_rn;
        n_d.lat.q = {i_d.lat.q[31:0], lat_bit};
        n_d.lon.q = {i_d.lon.q[31:0], lon_bit};
        if (K == 16) begin
            n_d.rb_s = lon_rnd;
            n_d.rb_t = lat_rnd;
        end
        if (K == 31) begin
            n_d.rb_lat = lat_rnd;
        end
        if (K == 32) begin
            n_d.rb_lon = lon_rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_v = r_v;
    assign o_d = r_d;

endmodule
`default_nettype wire

// File: rtl/core/usm_cordic_cell.sv
// One CORDIC rotation for the latitude and longitude lanes.
`default_nettype none
module usm_cordic_cell #(
    parameter int K = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_v,
    input  wire usm_pkg::t_cord i_d,
    output logic               o_v,
    output usm_pkg::t_cord     o_d
);

    localparam logic signed [33:0] ATAN = {4'b0, usm_pkg::ATAN_TURNS[K]};

    usm_pkg::t_cord n_d;
    usm_pkg::t_cord r_d;
    logic           r_v;
    logic signed [32:0] lat_xs, lat_ys, lon_xs, lon_ys;

    always_comb begin
        lat_xs = i_d.lat.x >>> K;
        lat_ys = i_d.lat.y >>> K;
        lon_xs = i_d.lon.x >>> K;
        lon_ys = i_d.lon.y >>> K;
        n_d = i_d;
        if (!i_d.lat.z[33]) begin
            n_d.lat.x = i_d.lat.x - lat_ys;
            n_d.lat.y = i_d.lat.y + lat_xs;
            n_d.lat.z = i_d.lat.z - ATAN;
        end else begin
            n_d.lat.x = i_d.lat.x + lat_ys;
            n_d.lat.y = i_d.lat.y - lat_xs;
            n_d.lat.z = i_d.lat.z + ATAN;
        end
        if (!i_d.lon.z[33]) begin
            n_d.lon.x = i_d.lon.x - lon_ys;
            n_d.lon.y = i_d.lon.y + lon_xs;
            n_d.lon.z = i_d.lon.z - ATAN;
        end else begin
            n_d.lon.x = i_d.lon.x + lon_ys;
            n_d.lon.y = i_d.lon.y - lon_xs;
            n_d.lon.z = i_d.lon.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_v = r_v;
    assign o_d = r_d;

endmodule
`default_nettype wire

// File: rtl/core/uv_sphere_mesh_generator.sv
// Top level: UV sphere vertex, normal and triangle generator.
//
//  channel | dir | handshake            | payload
//  input   | in  | i_valid / o_stall    | i_item (band_index, segment_index)
//  result  | out | o_valid / i_stall    | o_res  (kind, vectors, texcoords, corners)
//  config  | in  | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// One grid point accepted per cycle while o_stall is low; on its way to the
// result register it passes 32 division cells and CORDIC_STAGES rotation cells.
// Each point gives 1 to 4 results, one per cycle while i_stall is low, so the result
// port sets the sustained rate: one result for a rejected point, 2 to 4 otherwise.
// Synchronous active-low reset clears valid bits and config to defaults.
// A held result stalls the whole pipe once the last stage is occupied.
`default_nettype none
module uv_sphere_mesh_generator #(
    parameter int MAX_BANDS     = 255,
    parameter int MAX_SEGMENTS  = 255,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire usm_pkg::t_in i_item,
    output logic              o_valid,
    input  wire logic         i_stall,
    output usm_pkg::t_out     o_res,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [9:0]   i_cfg_data
);

    localparam int NDIV = 32;

    // configuration
    logic [9:0] r_radius;
    logic [7:0] r_bands, r_segs;
    logic [7:0] nb, ns;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 10'd1;
            r_bands  <= 8'd2;
            r_segs   <= 8'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                usm_pkg::CFG_RADIUS:   r_radius <= i_cfg_data;
                usm_pkg::CFG_BANDS:    r_bands  <= i_cfg_data[7:0];
                usm_pkg::CFG_SEGMENTS: r_segs   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_bands < 8'd2) nb = 8'd2;
        else if (r_bands > 8'(MAX_BANDS)) nb = 8'(MAX_BANDS);
        else nb = r_bands;
        if (r_segs < 8'd3) ns = 8'd3;
        else if (r_segs > 8'(MAX_SEGMENTS)) ns = 8'(MAX_SEGMENTS);
        else ns = r_segs;
    end

    logic en;

    // entry: range check, vertex indices and integer division step
    usm_pkg::t_div n_e, r_e;
    logic          r_ev;
    logic          lat_b0, lon_b0, in_cell;
    logic [16:0]   k1w;

    always_comb begin
        lat_b0  = i_item.band_index >= nb;
        lon_b0  = i_item.segment_index >= ns;
        in_cell = (i_item.band_index < nb) && (i_item.segment_index < ns);
        k1w     = 17'(i_item.band_index * ({1'b0, ns} + 9'd1))
                + {9'b0, i_item.segment_index};
        n_e          = '0;
        n_e.lat.r    = lat_b0 ? 8'(i_item.band_index - nb) : i_item.band_index;
        n_e.lon.r    = lon_b0 ? 8'(i_item.segment_index - ns) : i_item.segment_index;
        n_e.lat.q    = {32'b0, lat_b0};
        n_e.lon.q    = {32'b0, lon_b0};
        n_e.meta.rej = (i_item.band_index > nb) || (i_item.segment_index > ns);
        n_e.meta.up  = in_cell && (i_item.band_index != 8'd0);
        n_e.meta.lo  = in_cell && (i_item.band_index != 8'(nb - 8'd1));
        n_e.meta.k1  = k1w[15:0];
        n_e.meta.k2  = 16'(k1w[15:0] + {8'b0, ns} + 16'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= 1'b0;
        end else if (en) begin
            r_ev <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e <= n_e;
        end
    end

    // division chain: one fractional quotient bit per cell
    logic          dv [0:NDIV];
    usm_pkg::t_div dd [0:NDIV];

    assign dv[0] = r_ev;
    assign dd[0] = r_e;

    for (genvar g = 1; g <= NDIV; g++) begin : g_div
        usm_div_cell #(.K(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_v     (dv[g-1]),
            .i_d     (dd[g-1]),
            .i_nb    (nb),
            .i_ns    (ns),
            .o_v     (dv[g]),
            .o_d     (dd[g])
        );
    end

    // phases and texture coordinates
    logic          r_pv;
    logic [31:0]   r_lat_ph, r_lon_ph;
    usm_pkg::t_side r_p_side;
    usm_pkg::t_div  df;

    assign df = dd[NDIV];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (en) begin
            r_pv <= dv[NDIV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lat_ph <= 32'h4000_0000 - (df.lat.q[32:1] + {31'b0, df.rb_lat});
            r_lon_ph <= df.lon.q[31:0] + {31'b0, df.rb_lon};
            r_p_side.meta  <= df.meta;
            r_p_side.tex_s <= df.lon.q[32:16] + {16'b0, df.rb_s};
            r_p_side.tex_t <= df.lat.q[32:16] + {16'b0, df.rb_t};
        end
    end

    // quadrant reduction, residual in [-1/8, 1/8) turn
    logic [31:0]    lat_sum, lon_sum, lat_d, lon_d;
    usm_pkg::t_cord n_q, r_q;
    logic           r_qv;

    always_comb begin
        lat_sum = r_lat_ph + 32'h2000_0000;
        lon_sum = r_lon_ph + 32'h2000_0000;
        lat_d   = r_lat_ph - {lat_sum[31:30], 30'b0};
        lon_d   = r_lon_ph - {lon_sum[31:30], 30'b0};
        n_q.lat.x = usm_pkg::GAIN_Q30;
        n_q.lat.y = '0;
        n_q.lat.z = {{2{lat_d[31]}}, lat_d};
        n_q.lat.q = lat_sum[31:30];
        n_q.lon.x = usm_pkg::GAIN_Q30;
        n_q.lon.y = '0;
        n_q.lon.z = {{2{lon_d[31]}}, lon_d};
        n_q.lon.q = lon_sum[31:30];
        n_q.side  = r_p_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv <= 1'b0;
        end else if (en) begin
            r_qv <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q <= n_q;
        end
    end

    // rotation chain
    logic           cv [0:CORDIC_STAGES];
    usm_pkg::t_cord cd [0:CORDIC_STAGES];

    assign cv[0] = r_qv;
    assign cd[0] = r_q;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        usm_cordic_cell #(.K(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_v     (cv[g]),
            .i_d     (cd[g]),
            .o_v     (cv[g+1]),
            .o_d     (cd[g+1])
        );
    end

    // quadrant map and clamp
    usm_pkg::t_cord     cf;
    logic signed [32:0] cl_raw, sl_raw, co_raw, so_raw;
    logic signed [31:0] r_cl, r_sl, r_co, r_so;
    usm_pkg::t_side     r_m_side;
    logic               r_mv;

    assign cf = cd[CORDIC_STAGES];

    function automatic logic signed [31:0] clamp_unit(input logic signed [32:0] v);
        if (v > usm_pkg::ONE_Q30) return 32'sh4000_0000;
        if (v < -usm_pkg::ONE_Q30) return -32'sh4000_0000;
        return v[31:0];
    endfunction

    always_comb begin
        case (cf.lat.q)
            2'd0:    begin cl_raw = cf.lat.x;  sl_raw = cf.lat.y;  end
            2'd1:    begin cl_raw = -cf.lat.y; sl_raw = cf.lat.x;  end
            2'd2:    begin cl_raw = -cf.lat.x; sl_raw = -cf.lat.y; end
            default: begin cl_raw = cf.lat.y;  sl_raw = -cf.lat.x; end
        endcase
        case (cf.lon.q)
            2'd0:    begin co_raw = cf.lon.x;  so_raw = cf.lon.y;  end
            2'd1:    begin co_raw = -cf.lon.y; so_raw = cf.lon.x;  end
            2'd2:    begin co_raw = -cf.lon.x; so_raw = -cf.lon.y; end
            default: begin co_raw = cf.lon.y;  so_raw = -cf.lon.x; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (en) begin
            r_mv <= cv[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cl     <= clamp_unit(cl_raw);
            r_sl     <= clamp_unit(sl_raw);
            r_co     <= clamp_unit(co_raw);
            r_so     <= clamp_unit(so_raw);
            r_m_side <= cf.side;
        end
    end

    // direction products
    logic signed [63:0] r_px, r_py;
    logic signed [31:0] r_x_uz;
    usm_pkg::t_side     r_x_side;
    logic               r_xv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xv <= 1'b0;
        end else if (en) begin
            r_xv <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px     <= r_cl * r_co;
            r_py     <= r_cl * r_so;
            r_x_uz   <= r_sl;
            r_x_side <= r_m_side;
        end
    end

    // unit vector rounding
    logic signed [63:0] px_rnd, py_rnd;
    logic signed [31:0] r_ux, r_uy, r_uz;
    usm_pkg::t_side     r_u_side;
    logic               r_uv;

    assign px_rnd = (r_px + 64'sd536870912) >>> 30;
    assign py_rnd = (r_py + 64'sd536870912) >>> 30;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uv <= 1'b0;
        end else if (en) begin
            r_uv <= r_xv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ux     <= px_rnd[31:0];
            r_uy     <= py_rnd[31:0];
            r_uz     <= r_x_uz;
            r_u_side <= r_x_side;
        end
    end

    // scale by radius, normals
    logic signed [10:0] rad_s;
    logic signed [31:0] nx_w, ny_w, nz_w;
    logic signed [42:0] r_rx, r_ry, r_rz;
    logic signed [19:0] r_nx, r_ny, r_nz;
    usm_pkg::t_side     r_r_side;
    logic               r_rv;

    assign rad_s = {1'b0, r_radius};
    assign nx_w  = (r_ux + 32'sd32768) >>> 16;
    assign ny_w  = (r_uy + 32'sd32768) >>> 16;
    assign nz_w  = (r_uz + 32'sd32768) >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
        end else if (en) begin
            r_rv <= r_uv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rx     <= rad_s * r_ux;
            r_ry     <= rad_s * r_uy;
            r_rz     <= rad_s * r_uz;
            r_nx     <= nx_w[19:0];
            r_ny     <= ny_w[19:0];
            r_nz     <= nz_w[19:0];
            r_r_side <= r_u_side;
        end
    end

    // position rounding
    logic signed [42:0] qx_w, qy_w, qz_w;
    logic signed [19:0] r_fx, r_fy, r_fz, r_fnx, r_fny, r_fnz;
    usm_pkg::t_side     r_f_side;
    logic               r_fv;

    assign qx_w = (r_rx + 43'sd2097152) >>> 22;
    assign qy_w = (r_ry + 43'sd2097152) >>> 22;
    assign qz_w = (r_rz + 43'sd2097152) >>> 22;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (en) begin
            r_fv <= r_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fx     <= qx_w[19:0];
            r_fy     <= qy_w[19:0];
            r_fz     <= qz_w[19:0];
            r_fnx    <= r_nx;
            r_fny    <= r_ny;
            r_fnz    <= r_nz;
            r_f_side <= r_r_side;
        end
    end

    // result sequencer: plays out the results of one grid point
    logic               r_sq_v;
    logic [1:0]         r_sq_idx;
    logic signed [19:0] r_sx, r_sy, r_sz, r_snx, r_sny, r_snz;
    usm_pkg::t_side     r_s_side;
    logic [2:0]         sq_cnt;
    logic               sq_last, sq_free, ld;

    always_comb begin
        if (r_s_side.meta.rej) begin
            sq_cnt = 3'd1;
        end else begin
            sq_cnt = 3'd2 + {2'b0, r_s_side.meta.up} + {2'b0, r_s_side.meta.lo};
        end
        sq_last = {1'b0, r_sq_idx} == (sq_cnt - 3'd1);
        sq_free = !r_sq_v || (!i_stall && sq_last);
        en      = !r_fv || sq_free;
        ld      = en && r_fv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v   <= 1'b0;
            r_sq_idx <= 2'd0;
        end else if (ld) begin
            r_sq_v   <= 1'b1;
            r_sq_idx <= 2'd0;
        end else if (r_sq_v && !i_stall) begin
            if (sq_last) begin
                r_sq_v <= 1'b0;
            end else begin
                r_sq_idx <= r_sq_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_sx     <= r_fx;
            r_sy     <= r_fy;
            r_sz     <= r_fz;
            r_snx    <= r_fnx;
            r_sny    <= r_fny;
            r_snz    <= r_fnz;
            r_s_side <= r_f_side;
        end
    end

    always_comb begin
        o_res             = '0;
        o_res.last_of_run = sq_last;
        case (r_sq_idx)
            2'd0: begin
                if (r_s_side.meta.rej) begin
                    o_res.kind = usm_pkg::KIND_REJ;
                end else begin
                    o_res.kind  = usm_pkg::KIND_POS;
                    o_res.vec_x = r_sx;
                    o_res.vec_y = r_sy;
                    o_res.vec_z = r_sz;
                    o_res.tex_s = r_s_side.tex_s;
                    o_res.tex_t = r_s_side.tex_t;
                end
            end
            2'd1: begin
                o_res.kind  = usm_pkg::KIND_NORM;
                o_res.vec_x = r_snx;
                o_res.vec_y = r_sny;
                o_res.vec_z = r_snz;
            end
            2'd2: begin
                o_res.kind = usm_pkg::KIND_TRI;
                if (r_s_side.meta.up) begin
                    o_res.corner_a = r_s_side.meta.k1;
                    o_res.corner_b = r_s_side.meta.k2;
                    o_res.corner_c = r_s_side.meta.k1 + 16'd1;
                end else begin
                    o_res.corner_a = r_s_side.meta.k1 + 16'd1;
                    o_res.corner_b = r_s_side.meta.k2;
                    o_res.corner_c = r_s_side.meta.k2 + 16'd1;
                end
            end
            default: begin
                o_res.kind     = usm_pkg::KIND_TRI;
                o_res.corner_a = r_s_side.meta.k1 + 16'd1;
                o_res.corner_b = r_s_side.meta.k2;
                o_res.corner_c = r_s_side.meta.k2 + 16'd1;
            end
        endcase
    end

    assign o_valid = r_sq_v;
    assign o_stall = !en;

endmodule
`default_nettype wire

// File: rtl/core/usm_checker.sv
// Checker: port-level properties of the sphere generator, bound to the top level.
`default_nettype none
module usm_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         o_valid,
    input wire logic         i_stall,
    input wire usm_pkg::t_out o_res
);

    // a held result transaction stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res))
        else $error("result changed while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_rej_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.kind == usm_pkg::KIND_REJ |-> o_res.last_of_run)
        else $error("rejected point with further results");

    // the position always comes with its normal next
    a_pos_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_res.kind == usm_pkg::KIND_POS
        |-> !o_res.last_of_run)
        else $error("position without normal");

    a_tex_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.kind != usm_pkg::KIND_POS
        |-> o_res.tex_s == 17'd0 && o_res.tex_t == 17'd0)
        else $error("texture coordinates outside a position");

endmodule

bind uv_sphere_mesh_generator usm_checker u_usm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_res   (o_res)
);
`default_nettype wire
